>>> design/cpu_oar_pkg.sv
package cpu_oar_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned EA_BITS = 16;
  localparam int unsigned ADDRESS_BITS_DEFAULT = 16;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_RESOLVE = 1'b1;

  typedef enum logic [3:0] {
    MODE_IMM  = 4'd0,
    MODE_ZP   = 4'd1,
    MODE_ZPX  = 4'd2,
    MODE_ZPY  = 4'd3,
    MODE_ABS  = 4'd4,
    MODE_ABSX = 4'd5,
    MODE_ABSY = 4'd6,
    MODE_IND  = 4'd7,
    MODE_INDX = 4'd8,
    MODE_INDY = 4'd9
  } mode_t;

  typedef struct packed {
    logic [0:0]  req_type;
    logic [3:0]  mode;
    logic [7:0]  operand_low;
    logic [7:0]  operand_high;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [15:0] write_address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] effective_address;
    logic [7:0]  operand_value;
    logic        address_valid;
  } out_item_t;

  typedef enum logic [1:0] {
    CLS_IMM,
    CLS_DIRECT,
    CLS_INDIRECT,
    CLS_NONE
  } mode_class_t;

  typedef enum logic [1:0] {
    SEL_WRITE,
    SEL_PTR_LO,
    SEL_PTR_HI,
    SEL_EA
  } addr_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PTR_LO,
    ST_PTR_HI,
    ST_OPERAND,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic      capture;
    logic      mem_write;
    addr_sel_t addr_sel;
    logic      latch_lo;
    logic      latch_ea;
  } dp_cmd_t;

  typedef struct packed {
    logic        is_write;
    mode_class_t cls;
  } dp_status_t;

endpackage

>>> design/cpu_oar_ctrl.sv
module cpu_oar_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  cpu_oar_pkg::dp_status_t status,
  output logic                   busy,
  output logic                   done,
  output cpu_oar_pkg::dp_cmd_t   cmd
);

  cpu_oar_pkg::state_t state;
  cpu_oar_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpu_oar_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cpu_oar_pkg::ST_IDLE: begin
        if (start && !status.is_write) begin
          case (status.cls)
            cpu_oar_pkg::CLS_IMM:      state_next = cpu_oar_pkg::ST_RESULT;
            cpu_oar_pkg::CLS_DIRECT:   state_next = cpu_oar_pkg::ST_OPERAND;
            cpu_oar_pkg::CLS_INDIRECT: state_next = cpu_oar_pkg::ST_PTR_LO;
            default:                   state_next = cpu_oar_pkg::ST_IDLE;
          endcase
        end
      end
      cpu_oar_pkg::ST_PTR_LO:  state_next = cpu_oar_pkg::ST_PTR_HI;
      cpu_oar_pkg::ST_PTR_HI:  state_next = cpu_oar_pkg::ST_OPERAND;
      cpu_oar_pkg::ST_OPERAND: state_next = cpu_oar_pkg::ST_RESULT;
      cpu_oar_pkg::ST_RESULT:  state_next = cpu_oar_pkg::ST_IDLE;
      default:                 state_next = cpu_oar_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = 1'b1;
    done         = 1'b0;
    cmd.capture  = 1'b0;
    cmd.mem_write = 1'b0;
    cmd.addr_sel = cpu_oar_pkg::SEL_WRITE;
    cmd.latch_lo = 1'b0;
    cmd.latch_ea = 1'b0;
    case (state)
      cpu_oar_pkg::ST_IDLE: begin
        busy          = 1'b0;
        cmd.capture   = start;
        cmd.mem_write = start && status.is_write;
      end
      cpu_oar_pkg::ST_PTR_LO: begin
        cmd.addr_sel = cpu_oar_pkg::SEL_PTR_LO;
      end
      cpu_oar_pkg::ST_PTR_HI: begin
        // The low pointer byte arrives while the high byte is being read.
        cmd.addr_sel = cpu_oar_pkg::SEL_PTR_HI;
        cmd.latch_lo = 1'b1;
      end
      cpu_oar_pkg::ST_OPERAND: begin
        cmd.addr_sel = cpu_oar_pkg::SEL_EA;
        cmd.latch_ea = 1'b1;
      end
      cpu_oar_pkg::ST_RESULT: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

>>> design/cpu_oar_dp.sv
module cpu_oar_dp #(
  parameter int unsigned ADDRESS_BITS = cpu_oar_pkg::ADDRESS_BITS_DEFAULT
) (
  input  logic                     clk,
  input  cpu_oar_pkg::dp_cmd_t     cmd,
  input  cpu_oar_pkg::in_item_t    req,
  output cpu_oar_pkg::dp_status_t  status,
  output cpu_oar_pkg::out_item_t   result
);

  localparam int unsigned Depth = 2 ** ADDRESS_BITS;
  localparam logic [cpu_oar_pkg::EA_BITS-1:0] EaMask =
    cpu_oar_pkg::EA_BITS'((32'd1 << ADDRESS_BITS) - 32'd1);

  logic [7:0] mem [0:Depth-1];

  cpu_oar_pkg::in_item_t item;
  logic [7:0]  ptr_lo;
  logic [7:0]  rdata;
  logic [15:0] ea;

  logic [7:0]  zp_sum;
  logic [15:0] ptr_lo_addr;
  logic [15:0] ptr_hi_addr;
  logic [15:0] word;
  logic [15:0] ptr_word;
  logic [15:0] ea_calc;
  logic [ADDRESS_BITS-1:0] mem_addr;

  // Decode of the item on the input, used by the controller on acceptance.
  always_comb begin
    status.is_write = (req.req_type == cpu_oar_pkg::REQ_WRITE);
    case (req.mode)
      cpu_oar_pkg::MODE_IMM:  status.cls = cpu_oar_pkg::CLS_IMM;
      cpu_oar_pkg::MODE_ZP,
      cpu_oar_pkg::MODE_ZPX,
      cpu_oar_pkg::MODE_ZPY,
      cpu_oar_pkg::MODE_ABS,
      cpu_oar_pkg::MODE_ABSX,
      cpu_oar_pkg::MODE_ABSY: status.cls = cpu_oar_pkg::CLS_DIRECT;
      cpu_oar_pkg::MODE_IND,
      cpu_oar_pkg::MODE_INDX,
      cpu_oar_pkg::MODE_INDY: status.cls = cpu_oar_pkg::CLS_INDIRECT;
      default:                status.cls = cpu_oar_pkg::CLS_NONE;
    endcase
  end

  always_comb begin
    zp_sum   = 8'(item.operand_low + item.index_x);
    word     = {item.operand_high, item.operand_low};
    ptr_word = {rdata, ptr_lo};
    case (item.mode)
      cpu_oar_pkg::MODE_IND: begin
        // The high pointer byte comes from the same page as the low one.
        ptr_lo_addr = word;
        ptr_hi_addr = {item.operand_high, 8'(item.operand_low + 8'd1)};
      end
      cpu_oar_pkg::MODE_INDX: begin
        ptr_lo_addr = {8'h00, zp_sum};
        ptr_hi_addr = {8'h00, 8'(zp_sum + 8'd1)};
      end
      default: begin
        ptr_lo_addr = {8'h00, item.operand_low};
        ptr_hi_addr = {8'h00, 8'(item.operand_low + 8'd1)};
      end
    endcase
  end

  always_comb begin
    case (item.mode)
      cpu_oar_pkg::MODE_ZP:   ea_calc = {8'h00, item.operand_low};
      cpu_oar_pkg::MODE_ZPX:  ea_calc = {8'h00, zp_sum};
      cpu_oar_pkg::MODE_ZPY:  ea_calc = {8'h00, 8'(item.operand_low + item.index_y)};
      cpu_oar_pkg::MODE_ABS:  ea_calc = word;
      cpu_oar_pkg::MODE_ABSX: ea_calc = 16'(word + {8'h00, item.index_x});
      cpu_oar_pkg::MODE_ABSY: ea_calc = 16'(word + {8'h00, item.index_y});
      cpu_oar_pkg::MODE_IND,
      cpu_oar_pkg::MODE_INDX: ea_calc = ptr_word;
      cpu_oar_pkg::MODE_INDY: ea_calc = 16'(ptr_word + {8'h00, item.index_y});
      default:                ea_calc = 16'h0000;
    endcase
  end

  always_comb begin
    case (cmd.addr_sel)
      cpu_oar_pkg::SEL_WRITE:  mem_addr = req.write_address[ADDRESS_BITS-1:0];
      cpu_oar_pkg::SEL_PTR_LO: mem_addr = ptr_lo_addr[ADDRESS_BITS-1:0];
      cpu_oar_pkg::SEL_PTR_HI: mem_addr = ptr_hi_addr[ADDRESS_BITS-1:0];
      cpu_oar_pkg::SEL_EA:     mem_addr = ea_calc[ADDRESS_BITS-1:0];
      default:                 mem_addr = req.write_address[ADDRESS_BITS-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      mem[mem_addr] <= req.write_data;
    end
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= req;
    end
    if (cmd.latch_lo) begin
      ptr_lo <= rdata;
    end
    if (cmd.latch_ea) begin
      ea <= ea_calc & EaMask;
    end
  end

  always_comb begin
    if (item.mode == cpu_oar_pkg::MODE_IMM) begin
      result.effective_address = 16'h0000;
      result.operand_value     = item.operand_low;
      result.address_valid     = 1'b0;
    end else begin
      result.effective_address = ea;
      result.operand_value     = rdata;
      result.address_valid     = 1'b1;
    end
  end

endmodule

>>> design/cpu_operand_address_resolver_core.sv
// Operand address resolver for the classic 8-bit addressing modes, with its
// own single-port byte memory of 2**ADDRESS_BITS entries.
// An item is taken when start is high and busy is low. A write item stores
// write_data at write_address in that cycle and gives no result; the next
// item may follow in the very next cycle. A resolve item gives one result,
// shown on result for exactly one cycle while done is high; the receiver
// cannot stall it and must take it then.
// From acceptance to done, immediate goes straight to the result, zero page
// and absolute modes read the operand first. busy stays high until the
// cycle after done, so a resolve item is finished before the next is taken.
// The sequence is set by the single memory port: an indirect mode reads two
// pointer bytes and then the operand, one read per cycle.
// Resolve items with an unused mode are taken and dropped without a result.
// Reset clears the controller only; the memory keeps no reset value and
// must be written before it is read.
module cpu_operand_address_resolver_core #(
  parameter int unsigned ADDRESS_BITS = cpu_oar_pkg::ADDRESS_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  cpu_oar_pkg::in_item_t  req,
  output logic                   done,
  output cpu_oar_pkg::out_item_t result
);

  cpu_oar_pkg::dp_cmd_t    cmd;
  cpu_oar_pkg::dp_status_t status;

  cpu_oar_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd)
  );

  cpu_oar_dp #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .req    (req),
    .status (status),
    .result (result)
  );

  // Memory is written only by an accepted write beat.
  assert property (@(posedge clk) disable iff (rst)
    cmd.mem_write |-> (start && !busy && req.req_type == cpu_oar_pkg::REQ_WRITE))
    else $error("memory write without an accepted write beat");

  // A result is strobed for a single cycle.
  assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // An immediate result never reports an address.
  assert property (@(posedge clk) disable iff (rst)
    (done && !result.address_valid) |-> (result.effective_address == 16'h0000))
    else $error("immediate result with a non-zero address");

  // A resolve beat with a defined mode keeps the block busy afterwards.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.req_type == cpu_oar_pkg::REQ_RESOLVE &&
     req.mode <= cpu_oar_pkg::MODE_INDY) |=> busy)
    else $error("resolve beat accepted but block not busy");

endmodule
